### design/bce_pkg.sv
// Package for the battery charge estimator: widths, constants, the Li-ion
// discharge curve, the shared operand structs and the curve segment search.
// No dependencies.
`timescale 1ns / 1ps

package bce_pkg;

    // Burst length and burst counter widths.
    localparam int OVERSAMPLE = 16;
    localparam int IDX_W      = 6;
    localparam int SUM_W      = 18;
    localparam int GOOD_W     = 7;

    // Field widths.
    localparam int SAMPLE_W = 12;
    localparam int MV_W     = 14;
    localparam int PCT_W    = 7;
    localparam int DIVR_W   = 3;

    // Serial arithmetic widths: wide operand/product and narrow operand.
    localparam int DW         = 24;
    localparam int BW         = 12;
    localparam int MUL_STEPS  = BW;
    localparam int DIV_STEPS  = DW;
    localparam int MUL_CNT_W  = $clog2(MUL_STEPS);
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    // Conversion constants.
    localparam logic [MV_W-1:0]  NO_BATTERY_MV = 14'd2500;
    localparam logic [BW-1:0]    FULL_SCALE_MV = 12'd2500;
    localparam logic [BW-1:0]    ADC_MAX       = 12'd4095;
    localparam logic [MV_W-1:0]  CELL_MAX_MV   = 14'd10000;
    localparam logic [BW-1:0]    EMA_DIVISOR   = 12'd10;
    localparam logic [PCT_W-1:0] PCT_FULL      = 7'd100;
    localparam logic [PCT_W-1:0] PCT_EMPTY     = 7'd0;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIVIDER_NUM   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DIVIDER_DEN   = 2'd2;
    localparam int CFG_DATA_W = 7;

    // Discharge curve, highest voltage first.
    localparam int TABLE_POINTS = 12;
    localparam int SEG_IDX_W    = $clog2(TABLE_POINTS);
    localparam logic [MV_W-1:0] CURVE_MV [TABLE_POINTS] = '{
        14'd4180, 14'd4060, 14'd3980, 14'd3920, 14'd3870, 14'd3820,
        14'd3780, 14'd3740, 14'd3680, 14'd3550, 14'd3400, 14'd3250
    };
    localparam logic [PCT_W-1:0] CURVE_PCT [TABLE_POINTS] = '{
        7'd100, 7'd90, 7'd80, 7'd70, 7'd60, 7'd50,
        7'd40, 7'd30, 7'd20, 7'd10, 7'd5, 7'd0
    };

    // Operation request and response of the serial arithmetic units.
    typedef struct packed {
        logic          start;
        logic [DW-1:0] a;
        logic [BW-1:0] b;
    } bce_op_req_t;

    typedef struct packed {
        logic          done;
        logic [DW-1:0] value;
    } bce_op_rsp_t;

    // Index of the first curve segment whose lower end lies at or below mv.
    // Only meaningful for mv strictly inside the curve's range.
    function automatic logic [SEG_IDX_W-1:0] bce_find_seg(input logic [MV_W-1:0] mv);
        logic [SEG_IDX_W-1:0] seg;
        seg = '0;
        for (int i = TABLE_POINTS - 2; i >= 0; i--)
        begin
            if (mv >= CURVE_MV[i + 1])
            begin
                seg = SEG_IDX_W'(i);
            end
        end
        return seg;
    endfunction

endpackage

### design/bce_mul.sv
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle.
// Depends on bce_pkg.
`timescale 1ns / 1ps

module bce_mul (
    input  logic                 clk,
    input  logic                 rst_n,
    input  bce_pkg::bce_op_req_t req,
    output bce_pkg::bce_op_rsp_t rsp
);
    import bce_pkg::*;

    logic [DW-1:0]        acc_reg, acc_next;
    logic [DW-1:0]        a_reg, a_next;
    logic [BW-1:0]        b_reg, b_next;
    logic [MUL_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;

    always_comb
    begin
        acc_next  = acc_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            acc_next  = '0;
            a_next    = req.a;
            b_next    = req.b;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (b_reg[0])
            begin
                acc_next = acc_reg + a_reg;
            end
            a_next   = {a_reg[DW-2:0], 1'b0};
            b_next   = {1'b0, b_reg[BW-1:1]};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == MUL_CNT_W'(MUL_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
    end

    assign rsp.done  = done_reg;
    assign rsp.value = acc_reg;

endmodule

### design/bce_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on bce_pkg.
`timescale 1ns / 1ps

module bce_div (
    input  logic                 clk,
    input  logic                 rst_n,
    input  bce_pkg::bce_op_req_t req,
    output bce_pkg::bce_op_rsp_t rsp
);
    import bce_pkg::*;

    logic [BW-1:0]        rem_reg, rem_next;
    logic [DW-1:0]        quo_reg, quo_next;
    logic [BW-1:0]        dvs_reg, dvs_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [BW:0]          trial;
    logic [BW:0]          diff;

    // The dividend shifts out of the top of quo_reg while quotient bits enter below.
    assign trial = {rem_reg, quo_reg[DW-1]};
    assign diff  = trial - {1'b0, dvs_reg};

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            rem_next  = '0;
            quo_next  = req.a;
            dvs_next  = req.b;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = diff[BW-1:0];
                quo_next = {quo_reg[DW-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[BW-1:0];
                quo_next = {quo_reg[DW-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done  = done_reg;
    assign rsp.value = quo_reg;

endmodule

### design/battery_charge_estimator_core.sv
// Top level of the battery charge estimator: burst accumulator, sequencer and
// result register. Depends on bce_pkg, bce_mul and bce_div.
`timescale 1ns / 1ps

// Channel   Direction  Handshake          Payload
// s_*       in         s_tvalid/s_tready  tdata: raw_sample; tuser: read_ok
// m_*       out        m_tvalid/m_tready  tdata: filtered_mv, charge_pct, battery_low;
//                                         tuser: status
// cfg_*     in         cfg_valid/cfg_ready cfg_index, cfg_data (always ready)
//
// The last read of a burst starts a chain of serial operations on one bit-serial
// multiplier (12 steps) and one bit-serial divider (24 steps): the average, the pin
// voltage, the cell voltage, the filter update unless the filter is seeded, and the
// interpolation of the percent unless the filter lies outside the curve. The result
// register is loaded at the end of the chain. A burst whose reads all failed goes
// straight to the percent, interpolated from the kept filter value when it needs it.
// No read is taken during that chain.
// After reset the burst counters and the filter are zero and the registers hold
// their defaults. A stalled result holds in the output register; reads of the
// next burst are taken meanwhile, and its result waits until the slot is free.

module battery_charge_estimator_core (
    input  logic                            clk,
    input  logic                            rst_n,
    // Sample stream. s_tdata [11:0] raw_sample, [15:12] zero.
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [15:0]                     s_tdata,
    // s_tuser [0] read_ok.
    input  logic [0:0]                      s_tuser,
    // Result stream. m_tdata [13:0] filtered_mv, [20:14] charge_pct,
    // [21] battery_low, [23:22] zero.
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [23:0]                     m_tdata,
    // m_tuser [0] status.
    output logic [0:0]                      m_tuser,
    // Configuration write channel.
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [bce_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bce_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import bce_pkg::*;

    typedef enum logic [3:0] {
        S_ACC,
        S_AVG,
        S_PIN_MUL,
        S_PIN_DIV,
        S_CELL_MUL,
        S_CELL_DIV,
        S_EMA_DIV,
        S_SOC_SEG,
        S_SOC_MUL,
        S_SOC_DIV,
        S_OUT
    } state_t;

    state_t               state_reg, state_next;
    logic [IDX_W-1:0]     read_index_reg, read_index_next;
    logic [SUM_W-1:0]     raw_sum_reg, raw_sum_next;
    logic [GOOD_W-1:0]    good_reads_reg, good_reads_next;
    logic [MV_W-1:0]      filter_reg, filter_next;
    logic [DW-1:0]        op_a_reg, op_a_next;
    logic [BW-1:0]        op_b_reg, op_b_next;
    logic                 mul_start_reg, mul_start_next;
    logic                 div_start_reg, div_start_next;
    logic                 status_reg, status_next;
    logic [PCT_W-1:0]     pct_reg, pct_next;
    logic [PCT_W-1:0]     seg_pl_reg, seg_pl_next;
    logic [BW-1:0]        seg_span_reg, seg_span_next;
    logic                 m_valid_reg, m_valid_next;
    logic [MV_W-1:0]      out_mv_reg, out_mv_next;
    logic [PCT_W-1:0]     out_pct_reg, out_pct_next;
    logic                 out_low_reg, out_low_next;
    logic                 out_status_reg, out_status_next;
    logic [PCT_W-1:0]     low_thr_reg, low_thr_next;
    logic [DIVR_W-1:0]    div_num_reg, div_num_next;
    logic [DIVR_W-1:0]    div_den_reg, div_den_next;

    bce_op_req_t          mul_req, div_req;
    bce_op_rsp_t          mul_rsp, div_rsp;

    logic                 s_accept;
    logic [SUM_W-1:0]     sum_new;
    logic [GOOD_W-1:0]    good_new;
    logic [MV_W-1:0]      cell_mv;
    logic [SEG_IDX_W-1:0] seg;
    logic [SEG_IDX_W-1:0] seg_lo;

    assign s_tready  = (state_reg == S_ACC);
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign sum_new  = s_tuser[0] ? (raw_sum_reg + SUM_W'(s_tdata[SAMPLE_W-1:0])) : raw_sum_reg;
    assign good_new = s_tuser[0] ? (good_reads_reg + 1'b1) : good_reads_reg;

    // Cell voltage saturates at the top of the range before filtering.
    assign cell_mv = (div_rsp.value > DW'(CELL_MAX_MV)) ? CELL_MAX_MV
                                                        : div_rsp.value[MV_W-1:0];

    assign seg    = bce_find_seg(filter_reg);
    assign seg_lo = seg + 1'b1;

    assign mul_req.start = mul_start_reg;
    assign mul_req.a     = op_a_reg;
    assign mul_req.b     = op_b_reg;
    assign div_req.start = div_start_reg;
    assign div_req.a     = op_a_reg;
    assign div_req.b     = op_b_reg;

    bce_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .rsp   (mul_rsp)
    );

    bce_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    always_comb
    begin
        state_next      = state_reg;
        read_index_next = read_index_reg;
        raw_sum_next    = raw_sum_reg;
        good_reads_next = good_reads_reg;
        filter_next     = filter_reg;
        op_a_next       = op_a_reg;
        op_b_next       = op_b_reg;
        mul_start_next  = 1'b0;
        div_start_next  = 1'b0;
        status_next     = status_reg;
        pct_next        = pct_reg;
        seg_pl_next     = seg_pl_reg;
        seg_span_next   = seg_span_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        out_mv_next     = out_mv_reg;
        out_pct_next    = out_pct_reg;
        out_low_next    = out_low_reg;
        out_status_next = out_status_reg;
        low_thr_next    = low_thr_reg;
        div_num_next    = div_num_reg;
        div_den_next    = div_den_reg;

        // Register writes must arrive only while the sequencer is idle; the block itself does not enforce this.
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_LOW_THRESHOLD: low_thr_next = cfg_data[PCT_W-1:0];
                CFG_DIVIDER_NUM:   div_num_next = cfg_data[DIVR_W-1:0];
                CFG_DIVIDER_DEN:   div_den_next = cfg_data[DIVR_W-1:0];
                default:           ;
            endcase
        end

        unique case (state_reg)
            S_ACC:
            begin
                if (s_accept)
                begin
                    if (read_index_reg == IDX_W'(OVERSAMPLE - 1))
                    begin
                        // Last read of the burst: counters clear even if it failed.
                        read_index_next = '0;
                        raw_sum_next    = '0;
                        good_reads_next = '0;
                        if (good_new == '0)
                        begin
                            status_next = 1'b1;
                            state_next  = S_SOC_SEG;
                        end
                        else
                        begin
                            status_next    = 1'b0;
                            op_a_next      = DW'(sum_new);
                            op_b_next      = BW'(good_new);
                            div_start_next = 1'b1;
                            state_next     = S_AVG;
                        end
                    end
                    else
                    begin
                        read_index_next = read_index_reg + 1'b1;
                        raw_sum_next    = sum_new;
                        good_reads_next = good_new;
                    end
                end
            end
            S_AVG:
            begin
                if (div_rsp.done)
                begin
                    op_a_next      = DW'(div_rsp.value[SAMPLE_W-1:0]);
                    op_b_next      = FULL_SCALE_MV;
                    mul_start_next = 1'b1;
                    state_next     = S_PIN_MUL;
                end
            end
            S_PIN_MUL:
            begin
                if (mul_rsp.done)
                begin
                    op_a_next      = mul_rsp.value;
                    op_b_next      = ADC_MAX;
                    div_start_next = 1'b1;
                    state_next     = S_PIN_DIV;
                end
            end
            S_PIN_DIV:
            begin
                if (div_rsp.done)
                begin
                    op_a_next      = DW'(div_rsp.value[BW-1:0]);
                    op_b_next      = BW'(div_num_reg);
                    mul_start_next = 1'b1;
                    state_next     = S_CELL_MUL;
                end
            end
            S_CELL_MUL:
            begin
                if (mul_rsp.done)
                begin
                    op_a_next      = mul_rsp.value;
                    // A zero denominator counts as one.
                    op_b_next      = (div_den_reg == '0) ? BW'(1) : BW'(div_den_reg);
                    div_start_next = 1'b1;
                    state_next     = S_CELL_DIV;
                end
            end
            S_CELL_DIV:
            begin
                if (div_rsp.done)
                begin
                    if (filter_reg == '0)
                    begin
                        // An empty filter is seeded with the first cell voltage.
                        filter_next = cell_mv;
                        state_next  = S_SOC_SEG;
                    end
                    else
                    begin
                        op_a_next      = (DW'(cell_mv) << 1) + (DW'(filter_reg) << 3);
                        op_b_next      = EMA_DIVISOR;
                        div_start_next = 1'b1;
                        state_next     = S_EMA_DIV;
                    end
                end
            end
            S_EMA_DIV:
            begin
                if (div_rsp.done)
                begin
                    filter_next = div_rsp.value[MV_W-1:0];
                    state_next  = S_SOC_SEG;
                end
            end
            S_SOC_SEG:
            begin
                if (filter_reg < NO_BATTERY_MV || filter_reg >= CURVE_MV[0])
                begin
                    // No battery reads as full, as does a cell above the curve.
                    pct_next   = PCT_FULL;
                    state_next = S_OUT;
                end
                else if (filter_reg <= CURVE_MV[TABLE_POINTS - 1])
                begin
                    pct_next   = PCT_EMPTY;
                    state_next = S_OUT;
                end
                else
                begin
                    op_a_next      = DW'(filter_reg - CURVE_MV[seg_lo]);
                    op_b_next      = BW'(CURVE_PCT[seg] - CURVE_PCT[seg_lo]);
                    seg_pl_next    = CURVE_PCT[seg_lo];
                    seg_span_next  = BW'(CURVE_MV[seg] - CURVE_MV[seg_lo]);
                    mul_start_next = 1'b1;
                    state_next     = S_SOC_MUL;
                end
            end
            S_SOC_MUL:
            begin
                if (mul_rsp.done)
                begin
                    op_a_next      = mul_rsp.value;
                    op_b_next      = seg_span_reg;
                    div_start_next = 1'b1;
                    state_next     = S_SOC_DIV;
                end
            end
            S_SOC_DIV:
            begin
                if (div_rsp.done)
                begin
                    pct_next   = seg_pl_reg + div_rsp.value[PCT_W-1:0];
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next    = 1'b1;
                    out_mv_next     = filter_reg;
                    out_pct_next    = pct_reg;
                    out_low_next    = (filter_reg >= NO_BATTERY_MV) && (pct_reg < low_thr_reg);
                    out_status_next = status_reg;
                    state_next      = S_ACC;
                end
            end
            default:
            begin
                state_next = S_ACC;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_ACC;
            read_index_reg <= '0;
            raw_sum_reg    <= '0;
            good_reads_reg <= '0;
            filter_reg     <= '0;
            mul_start_reg  <= 1'b0;
            div_start_reg  <= 1'b0;
            status_reg     <= 1'b0;
            m_valid_reg    <= 1'b0;
            low_thr_reg    <= 7'd15;
            div_num_reg    <= 3'd2;
            div_den_reg    <= 3'd1;
        end
        else
        begin
            state_reg      <= state_next;
            read_index_reg <= read_index_next;
            raw_sum_reg    <= raw_sum_next;
            good_reads_reg <= good_reads_next;
            filter_reg     <= filter_next;
            mul_start_reg  <= mul_start_next;
            div_start_reg  <= div_start_next;
            status_reg     <= status_next;
            m_valid_reg    <= m_valid_next;
            low_thr_reg    <= low_thr_next;
            div_num_reg    <= div_num_next;
            div_den_reg    <= div_den_next;
        end
    end

    // Operands and the result payload carry no reset.
    always_ff @(posedge clk)
    begin
        op_a_reg       <= op_a_next;
        op_b_reg       <= op_b_next;
        pct_reg        <= pct_next;
        seg_pl_reg     <= seg_pl_next;
        seg_span_reg   <= seg_span_next;
        out_mv_reg     <= out_mv_next;
        out_pct_reg    <= out_pct_next;
        out_low_reg    <= out_low_next;
        out_status_reg <= out_status_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, out_low_reg, out_pct_reg, out_mv_reg};
    assign m_tuser  = out_status_reg;

endmodule

### design/bce_checker.sv
// Port-level checks on the battery charge estimator result stream, and the bind
// that attaches them to the top level. Depends on battery_charge_estimator_core.
`timescale 1ns / 1ps

module bce_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic [0:0]  m_tuser
);

    // A stalled result transaction keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // The state of charge never exceeds full.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[20:14] <= 7'd100)
        else $error("charge percent out of range");

    // Without a battery the charge reads full and never low.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[13:0] < 14'd2500 |-> m_tdata[20:14] == 7'd100 && !m_tdata[21])
        else $error("no-battery result wrong");

    // A cell at or above the top of the curve reads full.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[13:0] >= 14'd4180 |-> m_tdata[20:14] == 7'd100)
        else $error("full cell not reported full");

endmodule

bind battery_charge_estimator_core bce_checker u_bce_checker (.*);

### test/tb_battery_charge_estimator_core.sv
// Self-checking testbench for battery_charge_estimator_core: burst stimulus on the sample
// stream, results checked field by field against a predictor written here.
// Depends on bce_pkg and the estimator RTL; needs nothing else.
`timescale 1ns / 1ps

module tb_battery_charge_estimator_core;

    import bce_pkg::*;

    localparam int CYCLE_LIMIT      = 300000;
    localparam int SETTLE_CYCLES    = 250;   // longer than the end-of-burst arithmetic chain
    localparam int DRAIN_LIMIT      = 5000;
    localparam int HOLD_AFTER       = 12;    // results taken before the long receiver stall
    localparam int HOLD_CYCLES      = 600;
    localparam int NUM_PHASES       = 6;
    localparam int BURSTS_PER_PHASE = 5;
    localparam int DIR_ROWS         = 10;

    typedef struct packed {
        logic [MV_W-1:0]  mv;
        logic [PCT_W-1:0] pct;
        logic             low;
        logic             status;
    } charge_res_t;

    // One burst of identical samples; ok_mask bit i is read_ok of read i.
    typedef struct {
        logic [SAMPLE_W-1:0]   level;
        logic [OVERSAMPLE-1:0] ok_mask;
        bit                    typed;
        charge_res_t           want;
    } burst_row_t;

    typedef struct {
        int thr;
        int num;
        int den;
    } reg_set_t;

    typedef enum {SHAPE_LOST, SHAPE_SPARSE, SHAPE_NOISE, SHAPE_RAILS, SHAPE_STEADY} burst_shape_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [15:0]           s_tdata   = '0;
    logic [0:0]            s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [23:0]           m_tdata;
    logic [0:0]            m_tuser;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    battery_charge_estimator_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    // Predictor copy of the registers and of the burst and filter state.
    logic [PCT_W-1:0]  reg_thr    = 7'd15;
    logic [DIVR_W-1:0] reg_num    = 3'd2;
    logic [DIVR_W-1:0] reg_den    = 3'd1;
    logic [IDX_W-1:0]  burst_pos  = '0;
    logic [SUM_W-1:0]  burst_sum  = '0;
    logic [GOOD_W-1:0] burst_good = '0;
    logic [MV_W-1:0]   ema_mv     = '0;

    charge_res_t readings_due[$];

    int err_cnt    = 0;
    int cycle_cnt  = 0;
    int src_calm   = 0;
    int sink_calm  = 0;
    int n_reads    = 0;
    int n_bursts   = 0;
    int n_failed   = 0;
    int n_low      = 0;
    int n_nobatt   = 0;
    int n_clipped  = 0;

    // Directed bursts, run with the reset register values.
    burst_row_t dir_rows [DIR_ROWS] = '{
        '{12'hABC, 16'h0000, 1'b1, '{14'd0,    7'd100, 1'b0, 1'b1}}, // all lost, filter empty
        '{12'hFFF, 16'hFFFF, 1'b1, '{14'd5000, 7'd100, 1'b0, 1'b0}}, // full scale seeds filter
        '{12'h000, 16'h0000, 1'b1, '{14'd5000, 7'd100, 1'b0, 1'b1}}, // all lost, filter kept
        '{12'h000, 16'hFFFF, 1'b0, '0},                              // decay toward zero
        '{12'h000, 16'h0001, 1'b0, '0},                              // one good read, first
        '{12'h000, 16'h8000, 1'b0, '0},                              // one good read, last
        '{12'h000, 16'hFFFF, 1'b0, '0},                              // drops under no-battery
        '{12'hBB8, 16'hFFFF, 1'b0, '0},
        '{12'hE00, 16'h5A5A, 1'b0, '0},
        '{12'h555, 16'hFFFF, 1'b0, '0}
    };

    // Register settings per phase; the last phase draws its own.
    reg_set_t phase_regs [NUM_PHASES-1] = '{
        '{100, 4, 1},
        '{0,   1, 4},
        '{127, 7, 0},   // zero denominator, cell voltage clipped
        '{50,  3, 2},
        '{15,  0, 7}    // zero numerator drains the filter
    };

    task automatic flag_error(input string msg);
        if (err_cnt < 40)
            $display("ERROR @%0t: %s", $time, msg);
        err_cnt++;
    endtask

    function automatic int pick_gap(inout int calm);
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0)
        begin
            calm = $urandom_range(20, 40);
            return 0;
        end
        return $urandom_range(0, 6);
    endfunction

    // State of charge by linear interpolation over the discharge curve, rounding down.
    function automatic logic [PCT_W-1:0] soc_pct(input logic [MV_W-1:0] mv);
        int v;
        int hi;
        int lo;
        int ph;
        int pl;
        int k;
        v = int'(mv);
        if (mv < NO_BATTERY_MV || mv >= CURVE_MV[0])
            return PCT_FULL;
        if (mv <= CURVE_MV[TABLE_POINTS-1])
            return PCT_EMPTY;
        for (k = 0; k < TABLE_POINTS - 1; k++)
        begin
            hi = int'(CURVE_MV[k]);
            lo = int'(CURVE_MV[k+1]);
            ph = int'(CURVE_PCT[k]);
            pl = int'(CURVE_PCT[k+1]);
            if (v <= hi && v >= lo)
                return PCT_W'(pl + (v - lo) * (ph - pl) / (hi - lo));
        end
        return PCT_EMPTY;
    endfunction

    // Advances the predictor by one accepted read; returns 1 when the read closes a burst.
    function automatic bit estimate_read(input logic [SAMPLE_W-1:0] smp, input logic ok,
                                         output charge_res_t r);
        int avg;
        int pin;
        int cell_mv;
        int den_eff;
        r = '0;
        n_reads++;
        if (ok)
        begin
            burst_sum  = burst_sum + SUM_W'(smp);
            burst_good = burst_good + 1'b1;
        end
        if (int'(burst_pos) + 1 < OVERSAMPLE)
        begin
            burst_pos = burst_pos + 1'b1;
            return 1'b0;
        end
        n_bursts++;
        if (burst_good == '0)
        begin
            r.status = 1'b1;
            n_failed++;
        end
        else
        begin
            avg     = int'(burst_sum) / int'(burst_good);
            pin     = avg * int'(FULL_SCALE_MV) / int'(ADC_MAX);
            den_eff = (reg_den == '0) ? 1 : int'(reg_den);
            cell_mv = pin * int'(reg_num) / den_eff;
            if (cell_mv > int'(CELL_MAX_MV))
            begin
                cell_mv = int'(CELL_MAX_MV);
                n_clipped++;
            end
            if (ema_mv == '0)
                ema_mv = MV_W'(cell_mv);
            else
                ema_mv = MV_W'((2 * cell_mv + 8 * int'(ema_mv)) / int'(EMA_DIVISOR));
        end
        burst_pos  = '0;
        burst_sum  = '0;
        burst_good = '0;
        r.mv  = ema_mv;
        r.pct = soc_pct(ema_mv);
        r.low = (ema_mv >= NO_BATTERY_MV) && (r.pct < reg_thr);
        if (r.low)
            n_low++;
        if (ema_mv < NO_BATTERY_MV)
            n_nobatt++;
        return 1'b1;
    endfunction

    // Offers one read after a random gap; called and returning at a falling edge.
    task automatic push_read(input logic [SAMPLE_W-1:0] smp, input logic ok,
                             input bit typed, input charge_res_t want);
        int gap;
        charge_res_t r;
        gap = pick_gap(src_calm);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tdata  <= {4'b0, smp};
        s_tuser  <= ok;
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (s_tready !== 1'b1)
            @(posedge clk);
        if (estimate_read(smp, ok, r))
        begin
            if (typed)
                r = want;
            readings_due.push_back(r);
        end
        @(negedge clk);
    endtask

    task automatic random_burst();
        burst_shape_t shape;
        int pick;
        int want_mv;
        int level;
        int den_eff;
        int smp;
        int k;
        logic ok;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            shape = SHAPE_LOST;
        else if (pick == 1)
            shape = SHAPE_SPARSE;
        else if (pick == 2)
            shape = SHAPE_NOISE;
        else if (pick == 3)
            shape = SHAPE_RAILS;
        else
            shape = SHAPE_STEADY;
        // Aim the burst at a cell voltage around the discharge curve.
        want_mv = $urandom_range(2000, 4600);
        den_eff = (reg_den == '0) ? 1 : int'(reg_den);
        if (reg_num == '0)
            level = $urandom_range(0, int'(ADC_MAX));
        else
            level = want_mv * den_eff * int'(ADC_MAX) / (int'(reg_num) * int'(FULL_SCALE_MV));
        if (level > int'(ADC_MAX))
            level = int'(ADC_MAX);
        for (k = 0; k < OVERSAMPLE; k++)
        begin
            if (shape == SHAPE_LOST)
                ok = 1'b0;
            else if (shape == SHAPE_SPARSE)
                ok = ($urandom_range(0, 5) == 0);
            else
                ok = ($urandom_range(0, 15) != 0);
            if (shape == SHAPE_NOISE)
                smp = $urandom_range(0, int'(ADC_MAX));
            else if (shape == SHAPE_RAILS)
                smp = $urandom_range(0, 1) ? int'(ADC_MAX) : 0;
            else
            begin
                smp = level + int'($urandom_range(0, 16)) - 8;
                if (smp < 0)
                    smp = 0;
                if (smp > int'(ADC_MAX))
                    smp = int'(ADC_MAX);
            end
            push_read(SAMPLE_W'(smp), ok, 1'b0, '0);
        end
    endtask

    task automatic program_regs(input reg_set_t s);
        logic [CFG_IDX_W-1:0] idx [3];
        int val [3];
        int k;
        idx = '{CFG_LOW_THRESHOLD, CFG_DIVIDER_NUM, CFG_DIVIDER_DEN};
        val = '{s.thr, s.num, s.den};
        for (k = 0; k < 3; k++)
        begin
            cfg_index <= idx[k];
            cfg_data  <= CFG_DATA_W'(val[k]);
            cfg_valid <= 1'b1;
            @(posedge clk);
            while (cfg_ready !== 1'b1)
                @(posedge clk);
            case (idx[k])
                CFG_LOW_THRESHOLD: reg_thr = PCT_W'(val[k]);
                CFG_DIVIDER_NUM:   reg_num = DIVR_W'(val[k]);
                CFG_DIVIDER_DEN:   reg_den = DIVR_W'(val[k]);
                default: ;
            endcase
            @(negedge clk);
        end
        cfg_valid <= 1'b0;
    endtask

    // Stops offering reads, waits for every expected result, then lets the block settle.
    task automatic wait_idle();
        int n;
        s_tvalid <= 1'b0;
        n = 0;
        while (readings_due.size() != 0 && n < DRAIN_LIMIT)
        begin
            @(posedge clk);
            n++;
        end
        if (readings_due.size() != 0)
        begin
            flag_error($sformatf("%0d expected results never arrived", readings_due.size()));
            readings_due.delete();
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Result side: random stalls, one long hold-off, field-by-field comparison.
    initial
    begin : result_sink
        int gap;
        int got_n;
        charge_res_t want;
        charge_res_t got;
        got_n = 0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            gap = pick_gap(sink_calm);
            if (got_n == HOLD_AFTER)
                gap = gap + HOLD_CYCLES;
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (m_tvalid !== 1'b1)
                @(posedge clk);
            got.mv     = m_tdata[MV_W-1:0];
            got.pct    = m_tdata[MV_W +: PCT_W];
            got.low    = m_tdata[MV_W + PCT_W];
            got.status = m_tuser[0];
            if (readings_due.size() == 0)
                flag_error($sformatf("result with nothing expected: mv %0d pct %0d",
                                     got.mv, got.pct));
            else
            begin
                want = readings_due.pop_front();
                if (got.mv !== want.mv)
                    flag_error($sformatf("filtered_mv %0d, expected %0d", got.mv, want.mv));
                if (got.pct !== want.pct)
                    flag_error($sformatf("charge_pct %0d, expected %0d", got.pct, want.pct));
                if (got.low !== want.low)
                    flag_error($sformatf("battery_low %b, expected %b", got.low, want.low));
                if (got.status !== want.status)
                    flag_error($sformatf("status %b, expected %b", got.status, want.status));
            end
            got_n++;
            @(negedge clk);
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_cnt, readings_due.size());
            $display("** battery_charge_estimator_core: FAILED **");
            $finish;
        end
    end

    initial
    begin : stimulus
        int r;
        int i;
        int ph;
        int b;
        reg_set_t rs;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (r = 0; r < DIR_ROWS; r++)
            for (i = 0; i < OVERSAMPLE; i++)
                push_read(dir_rows[r].level, dir_rows[r].ok_mask[i], dir_rows[r].typed,
                          dir_rows[r].want);

        for (ph = 0; ph < NUM_PHASES; ph++)
        begin
            wait_idle();
            if (ph < NUM_PHASES - 1)
                rs = phase_regs[ph];
            else
            begin
                rs.thr = $urandom_range(0, 100);
                rs.num = $urandom_range(1, 4);
                rs.den = $urandom_range(1, 4);
            end
            program_regs(rs);
            for (b = 0; b < BURSTS_PER_PHASE; b++)
                random_burst();
        end
        wait_idle();

        $display("Covered %0d reads in %0d bursts (%0d fully failed) over %0d register settings.",
                 n_reads, n_bursts, n_failed, NUM_PHASES + 1);
        $display("Results flagged low: %0d, below no-battery level: %0d, clipped cell: %0d.",
                 n_low, n_nobatt, n_clipped);
        if (err_cnt == 0)
            $display("** battery_charge_estimator_core: PASSED **");
        else
            $display("** battery_charge_estimator_core: FAILED **");
        $finish;
    end

endmodule

### battery_charge_estimator_core.f
design/bce_pkg.sv
design/bce_mul.sv
design/bce_div.sv
design/battery_charge_estimator_core.sv
design/bce_checker.sv
test/tb_battery_charge_estimator_core.sv
